[src/mu8_pkg.sv]
// Shared types, result-kind codes and continuation-byte mask for the modified UTF-8 decoder.
package mu8_pkg;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_CHAR = 2'd0;
   localparam kind_type KIND_END  = 2'd1;
   localparam kind_type KIND_ERR  = 2'd2;

   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_MATCH = 8'h80;

endpackage

[src/modified_utf8_to_utf16_decoder.sv]
// Top level: modified UTF-8 byte stream to UTF-16 code unit decoder.
//
//   channel  direction  payload
//   req      in         tdata[7:0]  in_byte
//   rsp      out        tdata[15:0] code_unit, tuser[1:0] kind
//
// One byte per cycle unless stalled; a result appears the cycle after its last byte.
// Rate is set by the single output register, which refills in the cycle it is taken.
// Lead bytes give no result; sequence state lives in a 2-bit count and 10 gathered bits.
// A stalled result holds the output register; req_tready then falls.
// Reset, synchronous and active high, clears the sequence state and the output valid.
module modified_utf8_to_utf16_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] code_unit
   output logic [1:0]  rsp_tuser    // [1:0] kind
);

   logic [1:0]       pending_ff, pending_in;
   logic [9:0]       partial_ff, partial_in;
   logic             valid_ff, valid_in;
   logic [15:0]      unit_ff, unit_in;
   mu8_pkg::kind_type kind_ff, kind_in;

   logic             accept;
   logic             emit;
   logic [15:0]      unit_new;
   mu8_pkg::kind_type kind_new;
   logic [15:0]      acc;
   logic [1:0]       pending_dec;

   assign req_tready = !valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign acc        = {partial_ff, req_tdata[5:0]};
   assign pending_dec = pending_ff - 2'd1;

   always_comb begin
      pending_in = pending_ff;
      partial_in = partial_ff;
      emit       = 1'b0;
      unit_new   = '0;
      kind_new   = mu8_pkg::KIND_CHAR;
      if (pending_ff != 2'd0) begin
         if ((req_tdata & mu8_pkg::CONT_MASK) != mu8_pkg::CONT_MATCH) begin
            pending_in = 2'd0;
            partial_in = '0;
            emit       = 1'b1;
            kind_new   = mu8_pkg::KIND_ERR;
         end else if (pending_dec == 2'd0) begin
            pending_in = 2'd0;
            partial_in = '0;
            emit       = 1'b1;
            unit_new   = acc;
         end else begin
            pending_in = pending_dec;
            partial_in = acc[9:0];
         end
      end else begin
         case (req_tdata[7:4])
            4'h8, 4'h9, 4'hA, 4'hB, 4'hF: begin
               emit     = 1'b1;
               kind_new = mu8_pkg::KIND_ERR;
            end
            4'hC, 4'hD: begin
               pending_in = 2'd1;
               partial_in = {5'd0, req_tdata[4:0]};
            end
            4'hE: begin
               pending_in = 2'd2;
               partial_in = {6'd0, req_tdata[3:0]};
            end
            default: begin
               emit = 1'b1;
               if (req_tdata == 8'd0) begin
                  kind_new = mu8_pkg::KIND_END;
               end else begin
                  unit_new = {8'd0, req_tdata};
               end
            end
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      unit_in  = unit_ff;
      kind_in  = kind_ff;
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      if (accept && emit) begin
         valid_in = 1'b1;
         unit_in  = unit_new;
         kind_in  = kind_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
         partial_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (accept) begin
            pending_ff <= pending_in;
            partial_ff <= partial_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      unit_ff <= unit_in;
      kind_ff <= kind_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = unit_ff;
   assign rsp_tuser  = kind_ff;

   a_zero_unit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != mu8_pkg::KIND_CHAR) |-> rsp_tdata == 16'd0)
      else $error("non-character result carries a code unit");

   a_pending_range: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("pending count reached three");

   a_end_result: assert property (@(posedge clock) disable iff (reset)
      accept && (pending_ff == 2'd0) && (req_tdata == 8'd0)
      |=> rsp_tvalid && (rsp_tuser == mu8_pkg::KIND_END))
      else $error("end of string byte gave no end result");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while result stalled");

endmodule
